// ----- rtl/pira_pkg.sv -----
// Shared constants, codes and types of the positional insert/remove array.
`default_nettype none

package pira_pkg;

   localparam int DEPTH  = 64;
   localparam int WORD_W = 64;
   localparam int CNT_W  = 7;
   localparam int POS2_W = 6;
   localparam int MODE_W = 3;
   localparam int STAT_W = 2;
   localparam int GROUP  = 8;
   localparam int NGRP   = (DEPTH + GROUP - 1) / GROUP;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

   localparam logic [MODE_W-1:0] MODE_FILL   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SWAP   = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_FILL   = 3'd1,
      CELL_WRITE  = 3'd2,
      CELL_INSERT = 3'd3,
      CELL_REMOVE = 3'd4,
      CELL_SWAP   = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic [CNT_W-1:0]        pos;
      logic [POS2_W-1:0]       pos2;
      logic [CNT_W-1:0]        count;
      logic [WORD_W-1:0]       data;
      logic [WORD_W-1:0]       val_a;
      logic [WORD_W-1:0]       val_b;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/pira_ifs.sv -----
// Valid/ready channel interfaces for requests, responses and the capacity register.
`default_nettype none

interface pira_req_if;
   logic                                valid;
   logic                                ready;
   logic [pira_pkg::MODE_W-1:0]         mode;
   logic [pira_pkg::CNT_W-1:0]          index;
   logic [pira_pkg::POS2_W-1:0]         second_index;
   logic [pira_pkg::WORD_W-1:0]         data_value;

   modport source (output valid, mode, index, second_index, data_value, input ready);
   modport sink   (input valid, mode, index, second_index, data_value, output ready);
endinterface

interface pira_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [pira_pkg::WORD_W-1:0]         read_value;
   logic [pira_pkg::CNT_W-1:0]          entry_count;
   logic [pira_pkg::STAT_W-1:0]         status;

   modport source (output valid, read_value, entry_count, status, input ready);
   modport sink   (input valid, read_value, entry_count, status, output ready);
endinterface

interface pira_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pira_pkg::CNT_W-1:0]          capacity_limit;

   modport source (output valid, capacity_limit, input ready);
   modport sink   (input valid, capacity_limit, output ready);
endinterface

`default_nettype wire

// ----- rtl/pira_cell.sv -----
// One slot of the array: holds a word and loads from data, a neighbor or a swap word on command.
`default_nettype none

module pira_cell (
   input  wire                              clock,
   input  pira_pkg::cell_cmd_type           cmd,
   input  wire [pira_pkg::CNT_W-1:0]        cell_idx,
   input  wire [pira_pkg::WORD_W-1:0]       left_value,
   input  wire [pira_pkg::WORD_W-1:0]       right_value,
   output logic [pira_pkg::WORD_W-1:0]      slot_value,
   output logic [pira_pkg::WORD_W-1:0]      hit_a,
   output logic [pira_pkg::WORD_W-1:0]      hit_b
);
   import pira_pkg::*;

   logic [WORD_W-1:0] slot_ff;
   logic [WORD_W-1:0] slot_in;
   logic              eq_pos;
   logic              eq_pos2;

   assign eq_pos     = (cell_idx == cmd.pos);
   assign eq_pos2    = (cell_idx == CNT_W'(cmd.pos2));
   assign slot_value = slot_ff;
   assign hit_a      = eq_pos  ? slot_ff : '0;
   assign hit_b      = eq_pos2 ? slot_ff : '0;

   always_comb begin
      slot_in = slot_ff;
      unique case (cmd.op)
         CELL_FILL: begin
            if (cell_idx < cmd.pos) slot_in = cmd.data;
         end
         CELL_WRITE: begin
            if (eq_pos) slot_in = cmd.data;
         end
         CELL_INSERT: begin
            if (eq_pos) begin
               slot_in = cmd.data;
            end else if (cell_idx > cmd.pos && cell_idx <= cmd.count) begin
               slot_in = left_value;
            end
         end
         CELL_REMOVE: begin
            if (cell_idx >= cmd.pos) slot_in = right_value;
         end
         CELL_SWAP: begin
            if (eq_pos2) slot_in = cmd.val_a;
            if (eq_pos) slot_in = cmd.val_b;
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

// ----- rtl/pira_orgrp.sv -----
// Registered OR of one group of gated cell words, first level of the read tree.
`default_nettype none

module pira_orgrp (
   input  wire                                              clock,
   input  wire [pira_pkg::GROUP-1:0][pira_pkg::WORD_W-1:0]  in_a,
   input  wire [pira_pkg::GROUP-1:0][pira_pkg::WORD_W-1:0]  in_b,
   output logic [pira_pkg::WORD_W-1:0]                      grp_a,
   output logic [pira_pkg::WORD_W-1:0]                      grp_b
);
   import pira_pkg::*;

   logic [WORD_W-1:0] grp_a_ff, grp_a_in;
   logic [WORD_W-1:0] grp_b_ff, grp_b_in;

   always_comb begin
      grp_a_in = '0;
      grp_b_in = '0;
      for (int k = 0; k < GROUP; k++) begin
         grp_a_in = grp_a_in | in_a[k];
         grp_b_in = grp_b_in | in_b[k];
      end
   end

   always_ff @(posedge clock) begin
      grp_a_ff <= grp_a_in;
      grp_b_ff <= grp_b_in;
   end

   assign grp_a = grp_a_ff;
   assign grp_b = grp_b_ff;

endmodule

`default_nettype wire

// ----- rtl/positional_insert_remove_array_top.sv -----
// Top level of the positional insert/remove array: control, cell chain and read tree.
//
//   Channel | Direction | Beat contents
//   --------+-----------+----------------------------------------------------
//   req     | in        | mode, index, second_index, data_value
//   rsp     | out       | read_value, entry_count, status
//   csr     | in        | capacity_limit (the only register, no address)
//
// A request passes from its accepted beat to the response register through capture
// and check, a gather through a registered OR tree of eight-cell groups, one update
// of the whole chain, and the response load; the gather is the step the tree's register adds.
// Reset clears the count, the control state and the response valid, sets the
// capacity to 64 and leaves the slot words alone. A request accepted while a
// response waits stalls before its response load until that beat is taken.
`default_nettype none

module positional_insert_remove_array_top (
   input  wire        clock,
   input  wire        reset,
   pira_req_if.sink   req,
   pira_rsp_if.source rsp,
   pira_csr_if.sink   csr
);
   import pira_pkg::*;

   // One-hot control states.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_GATHER = 4'b0010,
      ST_APPLY  = 4'b0100,
      ST_SEND   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Request captured at the accepted beat, plus its precomputed outcome.
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [POS2_W-1:0] pos2_ff, pos2_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic [STAT_W-1:0] status_ff, status_in;
   cell_op_type       op_ff, op_in;
   logic              rd_ok_ff, rd_ok_in;

   // Array bookkeeping and the capacity register.
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  cap_eff;

   // Result waiting for the response register, and the response register itself.
   logic [WORD_W-1:0] pend_read_ff, pend_read_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_read_ff, rsp_read_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;

   logic              req_fire;
   logic              out_load;
   logic [STAT_W-1:0] chk_status;
   cell_op_type       chk_op;

   // Cell chain and read tree signals.
   cell_cmd_type                        cmd;
   logic [DEPTH-1:0][WORD_W-1:0]        slot_vals;
   logic [NGRP*GROUP-1:0][WORD_W-1:0]   hits_a;
   logic [NGRP*GROUP-1:0][WORD_W-1:0]   hits_b;
   logic [NGRP-1:0][WORD_W-1:0]         grp_a;
   logic [NGRP-1:0][WORD_W-1:0]         grp_b;
   logic [WORD_W-1:0]                   rd_a;
   logic [WORD_W-1:0]                   rd_b;

   // The configuration port never stalls; the user must write it only while the block is idle (not enforced here).
   assign csr.ready = 1'b1;
   assign cap_in    = (csr.valid) ? csr.capacity_limit : cap_ff;
   assign cap_eff   = (cap_ff > DEPTH_CNT) ? DEPTH_CNT : cap_ff;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign out_load  = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp.ready);

   // Range and full checks on the incoming beat. The count is stable while idle,
   // so the outcome is settled here and the later stages only carry it out.
   always_comb begin
      chk_status = STAT_OK;
      chk_op     = CELL_HOLD;
      unique case (req.mode)
         MODE_FILL: begin
            if (req.index > cap_eff) chk_status = STAT_RANGE;
            else chk_op = CELL_FILL;
         end
         MODE_READ: begin
            if (req.index >= cnt_ff) chk_status = STAT_RANGE;
         end
         MODE_WRITE: begin
            if (req.index >= cnt_ff) chk_status = STAT_RANGE;
            else chk_op = CELL_WRITE;
         end
         MODE_INSERT: begin
            // A bad position outranks a full array.
            priority if (req.index > cnt_ff) chk_status = STAT_RANGE;
            else if (cnt_ff >= cap_eff) chk_status = STAT_FULL;
            else chk_op = CELL_INSERT;
         end
         MODE_REMOVE: begin
            if (req.index >= cnt_ff) chk_status = STAT_RANGE;
            else chk_op = CELL_REMOVE;
         end
         MODE_SWAP: begin
            if (req.index >= cnt_ff || CNT_W'(req.second_index) >= cnt_ff) begin
               chk_status = STAT_RANGE;
            end else begin
               chk_op = CELL_SWAP;
            end
         end
         default: begin
            // Unused modes change nothing and report success.
            chk_status = STAT_OK;
         end
      endcase
   end

   // Final OR over the registered group words gives the two addressed slots.
   always_comb begin
      rd_a = '0;
      rd_b = '0;
      for (int g = 0; g < NGRP; g++) begin
         rd_a = rd_a | grp_a[g];
         rd_b = rd_b | grp_b[g];
      end
   end

   // The chain only moves in the apply state; otherwise every cell holds.
   always_comb begin
      cmd.op    = (state_ff == ST_APPLY) ? op_ff : CELL_HOLD;
      cmd.pos   = pos_ff;
      cmd.pos2  = pos2_ff;
      cmd.count = cnt_ff;
      cmd.data  = data_ff;
      cmd.val_a = rd_a;
      cmd.val_b = rd_b;
   end

   // Control sequencing and datapath next values.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      pos2_in      = pos2_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      op_in        = op_ff;
      rd_ok_in     = rd_ok_ff;
      cnt_in       = cnt_ff;
      pend_read_in = pend_read_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pos_in    = req.index;
               pos2_in   = req.second_index;
               data_in   = req.data_value;
               status_in = chk_status;
               op_in     = chk_op;
               rd_ok_in  = (req.mode == MODE_READ) && (chk_status == STAT_OK);
               state_in  = ST_GATHER;
            end
         end
         ST_GATHER: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            pend_read_in = rd_ok_ff ? rd_a : '0;
            unique case (op_ff)
               CELL_FILL:   cnt_in = pos_ff;
               CELL_INSERT: cnt_in = cnt_ff + CNT_W'(1);
               CELL_REMOVE: cnt_in = cnt_ff - CNT_W'(1);
               default:     cnt_in = cnt_ff;
            endcase
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: loaded from the send state, cleared when its beat is taken.
   always_comb begin
      rsp_read_in  = rsp_read_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_read_in  = pend_read_ff;
         rsp_cnt_in   = cnt_ff;
         rsp_stat_in  = status_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
         op_ff        <= CELL_HOLD;
         rd_ok_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         rd_ok_ff     <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      pos2_ff      <= pos2_in;
      data_ff      <= data_in;
      status_ff    <= status_in;
      pend_read_ff <= pend_read_in;
      rsp_read_ff  <= rsp_read_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.read_value  = rsp_read_ff;
   assign rsp.entry_count = rsp_cnt_ff;
   assign rsp.status      = rsp_stat_ff;

   // The chain of cells. Each cell sees both neighbors; the ends see zero.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] left_w;
      logic [WORD_W-1:0] right_w;

      if (i == 0) begin : g_left_end
         assign left_w = '0;
      end else begin : g_left
         assign left_w = slot_vals[i-1];
      end

      if (i == DEPTH - 1) begin : g_right_end
         assign right_w = '0;
      end else begin : g_right
         assign right_w = slot_vals[i+1];
      end

      pira_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_idx    (CNT_W'(i)),
         .left_value  (left_w),
         .right_value (right_w),
         .slot_value  (slot_vals[i]),
         .hit_a       (hits_a[i]),
         .hit_b       (hits_b[i])
      );
   end

   // Pad the last group when the depth is not a multiple of the group size.
   for (genvar j = DEPTH; j < NGRP * GROUP; j++) begin : g_pad
      assign hits_a[j] = '0;
      assign hits_b[j] = '0;
   end

   for (genvar g = 0; g < NGRP; g++) begin : g_grp
      pira_orgrp u_orgrp (
         .clock (clock),
         .in_a  (hits_a[g*GROUP +: GROUP]),
         .in_b  (hits_b[g*GROUP +: GROUP]),
         .grp_a (grp_a[g]),
         .grp_b (grp_b[g])
      );
   end

`ifndef ASSERT_OFF
   // The count can never pass the physical depth of the chain.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_CNT)
      else $error("entry count exceeds depth");

   // A failed request leaves the count untouched.
   a_fail_keeps_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && status_ff != STAT_OK) |=> $stable(cnt_ff))
      else $error("failed request changed the count");

   // A successful insert grows the count by exactly one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && op_ff == CELL_INSERT) |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("insert did not grow the count by one");

   // An accepted beat always moves on to the gather step.
   a_accept_gathers: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff == ST_GATHER)
      else $error("accepted request did not start its gather step");
`endif

endmodule

`default_nettype wire

// ----- tb/positional_insert_remove_array_top_tb.sv -----
// Self-checking testbench for the positional insert/remove array top level.
`default_nettype none

module positional_insert_remove_array_top_tb;
   import pira_pkg::*;

   // Modes six and seven are spare codes: the block must leave everything alone
   // and answer with an ok status.
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   // A comfortable settling window after the last response, longer than the path
   // from an accepted beat to its response register.
   localparam int SETTLE_CYCLES = 8;

   localparam logic [WORD_W-1:0] WORD_ONES    = '1;
   localparam logic [WORD_W-1:0] WORD_ZERO    = '0;
   localparam logic [WORD_W-1:0] WORD_PATTERN = 64'hA5A5_5A5A_C3C3_3C3C;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CNT_W-1:0]  index;
      logic [POS2_W-1:0] second_index;
      logic [WORD_W-1:0] data_value;
   } request_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_value;
      logic [CNT_W-1:0]  entry_count;
      logic [STAT_W-1:0] status;
   } response_type;

   // Full image of the array as the testbench believes it to be: every slot,
   // the number of valid entries and the capacity register.
   typedef struct packed {
      logic [DEPTH-1:0][WORD_W-1:0] slots;
      logic [CNT_W-1:0]             count;
      logic [CNT_W-1:0]             cap;
   } array_image_type;

   logic clock;
   logic reset;

   pira_req_if req_bus ();
   pira_rsp_if rsp_bus ();
   pira_csr_if csr_bus ();

   positional_insert_remove_array_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // Requests waiting to be driven, and the responses predicted for accepted
   // requests, oldest first.
   request_type     request_backlog[$];
   response_type    awaited_responses[$];

   // live_image follows the block beat by beat as requests are accepted;
   // plan_image runs ahead at generation time so that random requests can be
   // aimed at the positions that are currently valid.
   array_image_type live_image;
   array_image_type plan_image;

   int              errors;
   int              req_gap, req_calm;
   int              rsp_stall, rsp_calm;
   request_type     drive_beat;
   request_type     seen_beat;
   response_type    predicted;
   response_type    oldest;
   array_image_type stepped_image;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned effective_capacity(input logic [CNT_W-1:0] cap);
      return (cap > DEPTH) ? DEPTH : cap;
   endfunction

   // Applies one request to an image of the array and gives the response that
   // the block must return for it.
   function automatic void serve_request(input array_image_type now, input request_type r,
                                         output array_image_type after,
                                         output response_type res);
      int unsigned limit;
      int unsigned pos;
      int unsigned pos2;
      int unsigned cnt;
      after = now;
      res.read_value = '0;
      res.status = STAT_OK;
      limit = effective_capacity(now.cap);
      pos = 32'(r.index);
      pos2 = 32'(r.second_index);
      cnt = 32'(now.count);
      case (r.mode)
         MODE_FILL: begin
            if (pos > limit) begin
               res.status = STAT_RANGE;
            end else begin
               for (int i = 0; i < DEPTH; i++)
                  if (i < pos) after.slots[i] = r.data_value;
               after.count = r.index;
            end
         end
         MODE_READ: begin
            if (pos < cnt) res.read_value = now.slots[pos];
            else res.status = STAT_RANGE;
         end
         MODE_WRITE: begin
            if (pos < cnt) after.slots[pos] = r.data_value;
            else res.status = STAT_RANGE;
         end
         MODE_INSERT: begin
            // A bad position wins over a full array.
            if (pos > cnt) begin
               res.status = STAT_RANGE;
            end else if (cnt >= limit) begin
               res.status = STAT_FULL;
            end else begin
               for (int i = DEPTH - 1; i > 0; i--)
                  if (i <= cnt && i > pos) after.slots[i] = now.slots[i-1];
               after.slots[pos] = r.data_value;
               after.count = now.count + 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (pos < cnt) begin
               for (int i = 0; i < DEPTH - 1; i++)
                  if (i >= pos && i + 1 < cnt) after.slots[i] = now.slots[i+1];
               after.count = now.count - 1'b1;
            end else begin
               res.status = STAT_RANGE;
            end
         end
         MODE_SWAP: begin
            if (pos < cnt && pos2 < cnt) begin
               after.slots[pos]  = now.slots[pos2];
               after.slots[pos2] = now.slots[pos];
            end else begin
               res.status = STAT_RANGE;
            end
         end
         default: begin
         end
      endcase
      res.entry_count = after.count;
   endfunction

   // Mostly well-formed requests aimed at valid positions, with some noise:
   // any mode, any index, or an index right at one of the boundaries.
   function automatic request_type pick_request(input array_image_type s);
      request_type r;
      int unsigned cnt;
      int unsigned limit;
      int unsigned roll;
      cnt = 32'(s.count);
      limit = effective_capacity(s.cap);
      r.data_value = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll < 5) r.data_value = WORD_ONES;
      else if (roll < 10) r.data_value = WORD_ZERO;
      r.second_index = POS2_W'($urandom_range(0, DEPTH - 1));
      r.index = '0;
      if ($urandom_range(0, 99) < 15) begin
         r.mode = MODE_W'($urandom_range(MODE_FILL, MODE_SPARE_HI));
         if ($urandom_range(0, 1) == 0) begin
            r.index = CNT_W'($urandom);
         end else begin
            case ($urandom_range(0, 4))
               0: r.index = CNT_W'(cnt);
               1: r.index = CNT_W'(cnt + 1);
               2: r.index = CNT_W'(limit);
               3: r.index = CNT_W'(limit + 1);
               default: r.index = '1;
            endcase
         end
      end else begin
         roll = $urandom_range(0, 99);
         if (cnt == 0) begin
            if (roll < 70) begin
               r.mode = MODE_INSERT;
            end else begin
               r.mode = MODE_FILL;
               r.index = CNT_W'($urandom_range(0, limit));
            end
         end else if (roll < 5) begin
            r.mode = MODE_FILL;
            r.index = CNT_W'($urandom_range(0, limit));
         end else if (roll < 35) begin
            r.mode = MODE_INSERT;
            r.index = CNT_W'($urandom_range(0, cnt));
         end else if (roll < 55) begin
            r.mode = MODE_REMOVE;
            r.index = CNT_W'($urandom_range(0, cnt - 1));
         end else if (roll < 75) begin
            r.mode = MODE_READ;
            r.index = CNT_W'($urandom_range(0, cnt - 1));
         end else if (roll < 90) begin
            r.mode = MODE_WRITE;
            r.index = CNT_W'($urandom_range(0, cnt - 1));
         end else begin
            r.mode = MODE_SWAP;
            r.index = CNT_W'($urandom_range(0, cnt - 1));
            r.second_index = POS2_W'($urandom_range(0, cnt - 1));
         end
      end
      return r;
   endfunction

   // Idle lengths: usually none or a few cycles, now and then a long one, and
   // from time to time a stretch of beats with no idling at all.
   task automatic draw_gap(inout int calm, output int gap);
      int unsigned roll;
      if (calm > 0) begin
         calm--;
         gap = 0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            calm = $urandom_range(30, 120);
            gap = 0;
         end else if (roll < 55) begin
            gap = 0;
         end else if (roll < 85) begin
            gap = $urandom_range(1, 3);
         end else if (roll < 97) begin
            gap = $urandom_range(4, 12);
         end else begin
            gap = $urandom_range(20, 60);
         end
      end
   endtask

   // Request driver: a new beat is offered only once the current one has been
   // taken, after the idle cycles drawn for it.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            drive_beat = request_backlog.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.mode         <= drive_beat.mode;
            req_bus.index        <= drive_beat.index;
            req_bus.second_index <= drive_beat.second_index;
            req_bus.data_value   <= drive_beat.data_value;
            draw_gap(req_calm, req_gap);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         draw_gap(rsp_calm, rsp_stall);
      end
   end

   // Monitor: the oldest prediction is settled before the request accepted on
   // the same edge is predicted, since a response can never overtake its own
   // request. A capacity write takes effect for the requests after it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_responses.size() == 0) begin
               $display("%0t: unexpected response beat: read_value %h entry_count %0d status %0d",
                        $time, rsp_bus.read_value, rsp_bus.entry_count, rsp_bus.status);
               errors++;
            end else begin
               oldest = awaited_responses.pop_front();
               if (rsp_bus.read_value !== oldest.read_value) begin
                  $display("%0t: read_value expected %h, actual %h",
                           $time, oldest.read_value, rsp_bus.read_value);
                  errors++;
               end
               if (rsp_bus.entry_count !== oldest.entry_count) begin
                  $display("%0t: entry_count expected %0d, actual %0d",
                           $time, oldest.entry_count, rsp_bus.entry_count);
                  errors++;
               end
               if (rsp_bus.status !== oldest.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, oldest.status, rsp_bus.status);
                  errors++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_beat.mode         = req_bus.mode;
            seen_beat.index        = req_bus.index;
            seen_beat.second_index = req_bus.second_index;
            seen_beat.data_value   = req_bus.data_value;
            serve_request(live_image, seen_beat, stepped_image, predicted);
            live_image = stepped_image;
            awaited_responses.push_back(predicted);
         end
         if (csr_bus.valid && csr_bus.ready) live_image.cap = csr_bus.capacity_limit;
      end
   end

   // Queues one request and advances the planning image past it.
   task automatic queue_request(input logic [MODE_W-1:0] mode, input logic [CNT_W-1:0] index,
                                input logic [POS2_W-1:0] second_index,
                                input logic [WORD_W-1:0] data_value);
      request_type     r;
      array_image_type after;
      response_type    unused;
      r.mode = mode;
      r.index = index;
      r.second_index = second_index;
      r.data_value = data_value;
      serve_request(plan_image, r, after, unused);
      plan_image = after;
      request_backlog.push_back(r);
   endtask

   // Holds the sender back until every request has been answered, then lets the
   // block settle.
   task automatic drain;
      while (request_backlog.size() != 0 || req_bus.valid || awaited_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Capacity writes happen only while the block is idle.
   task automatic write_capacity(input logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_bus.valid          <= 1'b1;
      csr_bus.capacity_limit <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      plan_image.cap = value;
   endtask

   // A random phase, split in two halves with a full drain in between so the
   // sender also pauses while results are still outstanding.
   task automatic run_random(input int items);
      request_type r;
      for (int i = 0; i < items; i++) begin
         if (i == items / 2) drain();
         r = pick_request(plan_image);
         queue_request(r.mode, r.index, r.second_index, r.data_value);
      end
      drain();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      errors = 0;
      req_gap = 0;
      req_calm = 0;
      rsp_stall = 0;
      rsp_calm = 0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_FILL;
      req_bus.index = '0;
      req_bus.second_index = '0;
      req_bus.data_value = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.capacity_limit = CAP_RESET;
      live_image = '0;
      live_image.cap = CAP_RESET;
      plan_image = live_image;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from an empty array at the reset capacity.
      queue_request(MODE_READ,   0,  0, WORD_ZERO);     // read of an empty array
      queue_request(MODE_REMOVE, 0,  0, WORD_ZERO);     // remove from an empty array
      queue_request(MODE_SWAP,   0,  0, WORD_ZERO);     // swap in an empty array
      queue_request(MODE_INSERT, 1,  0, WORD_ZERO);     // insert past the end
      queue_request(MODE_INSERT, 0,  0, WORD_ONES);
      queue_request(MODE_FILL,   65, 0, WORD_ONES);     // fill above capacity
      queue_request(MODE_FILL,   '1, 0, WORD_ONES);     // largest fill count
      queue_request(MODE_FILL,   64, 0, WORD_PATTERN);  // fill to the top
      queue_request(MODE_INSERT, 64, 0, WORD_ONES);     // insert when full
      queue_request(MODE_INSERT, 65, 0, WORD_ONES);     // bad position beats full
      queue_request(MODE_WRITE,  63, 0, WORD_ONES);
      queue_request(MODE_READ,   63, 0, WORD_ZERO);
      queue_request(MODE_READ,   64, 0, WORD_ZERO);
      queue_request(MODE_WRITE,  64, 0, WORD_ONES);
      queue_request(MODE_SWAP,   0, 63, WORD_ZERO);
      queue_request(MODE_READ,   0,  0, WORD_ZERO);
      queue_request(MODE_REMOVE, 63, 0, WORD_ZERO);
      queue_request(MODE_SWAP,   0, 63, WORD_ZERO);     // second index now out of range
      queue_request(MODE_INSERT, 63, 0, WORD_ZERO);     // insert at the end
      queue_request(MODE_REMOVE, 0,  0, WORD_ZERO);
      queue_request(MODE_INSERT, 0,  0, WORD_ONES);     // insert at the front
      queue_request(MODE_READ,   1,  0, WORD_ZERO);
      queue_request(MODE_SPARE_LO, 0,  0, WORD_ZERO);
      queue_request(MODE_SPARE_HI, '1, '1, WORD_ONES);
      queue_request(MODE_FILL,   0,  0, WORD_ONES);     // a fill of zero empties it
      queue_request(MODE_READ,   0,  0, WORD_ZERO);
      drain();

      run_random(200);

      // Lower the capacity below the count: the entries stay, inserts report
      // full until enough removes bring the count under the new limit.
      queue_request(MODE_FILL, 40, 0, WORD_PATTERN);
      drain();
      write_capacity(5);
      queue_request(MODE_INSERT, 0, 0, WORD_ONES);
      while (plan_image.count >= 5)
         queue_request(MODE_REMOVE, CNT_W'($urandom_range(0, plan_image.count - 1)), 0,
                       WORD_ZERO);
      run_random(200);

      write_capacity(1);
      run_random(150);

      // With no capacity at all no insert succeeds and only an empty fill does.
      write_capacity(0);
      queue_request(MODE_FILL,   1, 0, WORD_ONES);
      queue_request(MODE_INSERT, 0, 0, WORD_ONES);
      queue_request(MODE_FILL,   0, 0, WORD_ONES);
      queue_request(MODE_INSERT, 0, 0, WORD_ONES);
      run_random(100);

      // Above the depth the limit clamps to the depth.
      write_capacity('1);
      queue_request(MODE_FILL, 65, 0, WORD_ONES);
      queue_request(MODE_FILL, 64, 0, WORD_ONES);
      run_random(250);

      write_capacity(CAP_RESET);
      run_random(250);

      write_capacity(CNT_W'($urandom_range(2, DEPTH - 1)));
      run_random(250);

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #8000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
